@@ rtl/cecs_pkg.sv @@
// shared widths, codes and record types of the capacity cut search
// no dependencies; the divider, sequencer and top level import it
package cecs_pkg;

   localparam int MAX_NODES = 16;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int NODE_FLD_W = 4;
   localparam int VALUE_W    = 18;
   localparam int DEMAND_W   = 16;
   localparam int CAP_W      = 16;
   localparam int TOL_W      = 16;
   localparam int NCFG_W     = 5;
   localparam int MASK_W     = 15;
   localparam int BOUND_W    = 21;
   localparam int CUT_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int CODE_W     = 2;

   localparam int BOUND_MAX  = 2097151;
   localparam int WEIGHT_MAX = 255;

   // widths that follow from the node count
   localparam int NODE_W     = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
   localparam int NCNT_W     = $clog2(MAX_NODES + 1);
   localparam int CUST_W     = MAX_NODES - 1;
   localparam int EDGE_DEPTH = MAX_NODES << NODE_W;
   localparam int MAX_CROSS  = 2 * (MAX_NODES / 2) * (MAX_NODES - MAX_NODES / 2);
   localparam int WGT_RAW_W  = $clog2(MAX_CROSS + 1);
   localparam int WGT_W      = (WGT_RAW_W > CUT_W) ? WGT_RAW_W : CUT_W;
   localparam int DEM_W      = DEMAND_W + $clog2(MAX_NODES);
   localparam int NUM_W      = DEM_W + 2;
   localparam int PROD_W     = WGT_W + CAP_W;
   localparam int CMP_W      = (PROD_W > DEM_W + 1) ? PROD_W : DEM_W + 1;
   localparam int SAT_W      = (NUM_W > BOUND_W) ? NUM_W : BOUND_W;

   // operation codes
   localparam logic [OP_W-1:0] OP_EDGE   = 2'd0;
   localparam logic [OP_W-1:0] OP_DEMAND = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

   typedef struct packed {
      logic                  en;
      logic [2*NODE_W-1:0]   edge_addr;
      logic [NODE_W-1:0]     dem_addr;
   } cecs_read_type;

   typedef struct packed {
      logic                  found;
      logic [MASK_W-1:0]     mask;
      logic [BOUND_W-1:0]    bound;
      logic [CUT_W-1:0]      weight;
   } cecs_result_type;

   typedef struct packed {
      logic                  start;
      logic [NUM_W-1:0]      num;
      logic [CAP_W-1:0]      den;
   } cecs_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [NUM_W-1:0]      quotient;
   } cecs_div_sts_type;

   // node zero is never in the subset; node j sits at bit j-1
   function automatic logic node_in_set(input logic [CUST_W-1:0] sub,
                                        input logic [NODE_W-1:0] node);
      logic [NODE_W-1:0] idx;
      idx = node - 1'b1;
      return (node != '0) && sub[idx];
   endfunction

endpackage

@@ rtl/cecs_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module cecs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cecs_divider.sv @@
// restoring divider, one quotient bit per cycle, for the cut bound
// depends on cecs_pkg
module cecs_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  cecs_pkg::cecs_div_req_type   req,
   output cecs_pkg::cecs_div_sts_type   sts
);
   import cecs_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CAP_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [CAP_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CAP_W:0]   shifted;
   logic [CAP_W:0]   diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      ge      = shifted >= {1'b0, den_ff};
      diff    = shifted - {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = '0;
         quo_in  = req.num;
         den_in  = req.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CAP_W-1:0] : shifted[CAP_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

@@ rtl/cecs_engine.sv @@
// subset sequencer: sweeps the code and demand memories for each subset,
// tests the cut and drives the bound divider; depends on cecs_pkg, cecs_divider
module cecs_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cecs_pkg::NCNT_W-1:0]   node_num,
   input  logic [cecs_pkg::CAP_W-1:0]    capacity,
   input  logic                          out_free,
   input  logic [cecs_pkg::CODE_W-1:0]   edge_rd_data,
   input  logic [cecs_pkg::DEMAND_W-1:0] dem_rd_data,
   output cecs_pkg::cecs_read_type       rd,
   output logic                          idle,
   output logic                          res_valid,
   output cecs_pkg::cecs_result_type     res
);
   import cecs_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SCAN  = 7'b0000010,
      S_DRAIN = 7'b0000100,
      S_MUL   = 7'b0001000,
      S_TEST  = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CUST_W-1:0]     sub_ff, sub_in;
   logic [NODE_W-1:0]     p_ff, p_in, q_ff, q_in;
   logic [NODE_W-1:0]     pd_ff, qd_ff;
   logic                  rd_vld_ff, rd_vld_in;
   logic [WGT_W-1:0]      wgt_ff, wgt_in;
   logic [DEM_W-1:0]      dem_ff, dem_in;
   logic [CMP_W-1:0]      prod_ff, prod_in;
   cecs_result_type       res_ff, res_in;
   cecs_div_req_type      div_req;
   cecs_div_sts_type      div_sts;

   logic [NODE_W-1:0]     last_node;
   logic [CUST_W-1:0]     last_sub;
   logic [CUST_W+MASK_W-1:0] mask_wide;
   logic [SAT_W-1:0]      quo_wide;
   logic                  pd_in_a, qd_in_a;

   cecs_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .sts   (div_sts)
   );

   always_comb begin
      last_node = NODE_W'(node_num - 1'b1);
      last_sub  = ~({CUST_W{1'b1}} << last_node);
      mask_wide = {{MASK_W{1'b0}}, sub_ff};
      quo_wide  = SAT_W'(div_sts.quotient);
      pd_in_a   = node_in_set(sub_ff, pd_ff);
      qd_in_a   = node_in_set(sub_ff, qd_ff);

      state_in  = state_ff;
      sub_in    = sub_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      wgt_in    = wgt_ff;
      dem_in    = dem_ff;
      prod_in   = prod_ff;
      res_in    = res_ff;
      rd_vld_in = 1'b0;
      res_valid = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = NUM_W'({dem_ff, 1'b0}) + NUM_W'(capacity) - 1'b1;
      div_req.den   = capacity;

      rd.en        = (state_ff == S_SCAN);
      rd.edge_addr = {p_ff, q_ff};
      rd.dem_addr  = p_ff;

      // accumulate the word read in the previous cycle
      if (rd_vld_ff) begin
         if (pd_ff == qd_ff) begin
            if (pd_in_a) begin
               dem_in = dem_ff + DEM_W'(dem_rd_data);
            end
         end else if (pd_in_a != qd_in_a) begin
            wgt_in = wgt_ff + WGT_W'(edge_rd_data);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               res_in = '0;
               sub_in = CUST_W'(1);
               p_in   = '0;
               q_in   = '0;
               wgt_in = '0;
               dem_in = '0;
               state_in = (node_num < NCNT_W'(2)) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            rd_vld_in = 1'b1;
            if (q_ff == last_node) begin
               if (p_ff == last_node) begin
                  state_in = S_DRAIN;
               end else begin
                  p_in = p_ff + 1'b1;
                  q_in = p_ff + 1'b1;
               end
            end else begin
               q_in = q_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = CMP_W'(wgt_ff) * CMP_W'(capacity);
            state_in = S_TEST;
         end
         S_TEST: begin
            if (CMP_W'({dem_ff, 1'b0}) > prod_ff) begin
               div_req.start = 1'b1;
               res_in.found  = 1'b1;
               res_in.mask   = mask_wide[MASK_W-1:0];
               res_in.weight = (wgt_ff > WGT_W'(WEIGHT_MAX)) ? CUT_W'(WEIGHT_MAX)
                                                              : wgt_ff[CUT_W-1:0];
               state_in = S_DIV;
            end else if (sub_ff == last_sub) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               sub_in   = sub_ff + 1'b1;
               p_in     = '0;
               q_in     = '0;
               wgt_in   = '0;
               dem_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_DIV: begin
            if (div_sts.done) begin
               res_in.bound = (quo_wide > SAT_W'(BOUND_MAX)) ? BOUND_W'(BOUND_MAX)
                                                             : quo_wide[BOUND_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_vld_in;
      end
      sub_ff  <= sub_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      pd_ff   <= p_ff;
      qd_ff   <= q_ff;
      wgt_ff  <= wgt_in;
      dem_ff  <= dem_in;
      prod_ff <= prod_in;
      res_ff  <= res_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign res  = res_ff;

endmodule

@@ rtl/exhaustive_capacity_cut_search.sv @@
// top level of the exhaustive capacity cut search: registers, loads, memories
// depends on cecs_pkg, cecs_ram, cecs_engine
//
// Edge and demand loads are taken one per cycle while the sequencer is idle
// and write the code or demand memory at the transfer; they give no result. A
// search item runs through the customer subsets in counter order and gives one
// result. For each subset the sequencer reads every node pair and every node,
// n being the node count in use, through the single read port of the code
// memory, then takes the drain, multiply and test steps. Up to 2^(n-1)-1 subsets
// are visited; a hit stops the sweep and runs the bit-serial bound divider.
// Loads and register writes are taken while a finished result waits on the
// output; a search is taken only once the previous one has left the sequencer.
// The memories are not cleared at reset: an entry is valid once written.
module exhaustive_capacity_cut_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cecs_pkg::OP_W-1:0]       req_operation,
   input  logic [cecs_pkg::NODE_FLD_W-1:0] req_node_a,
   input  logic [cecs_pkg::NODE_FLD_W-1:0] req_node_b,
   input  logic [cecs_pkg::VALUE_W-1:0]    req_edge_value,
   input  logic [cecs_pkg::DEMAND_W-1:0]   req_node_demand,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_found,
   output logic [cecs_pkg::MASK_W-1:0]     rsp_subset_mask,
   output logic [cecs_pkg::BOUND_W-1:0]    rsp_cut_bound,
   output logic [cecs_pkg::CUT_W-1:0]      rsp_cut_weight,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cecs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cecs_pkg::CSR_DATA_W-1:0] csr_data
);
   import cecs_pkg::*;

   localparam logic [VALUE_W-1:0] ONE_FIX = VALUE_W'(65536);

   logic [NCFG_W-1:0]  node_count_ff, node_count_in;
   logic [CAP_W-1:0]   capacity_ff, capacity_in;
   logic [TOL_W-1:0]   tolerance_ff, tolerance_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cecs_result_type    rsp_ff, rsp_in;

   logic               req_xfer;
   logic               edge_wr, dem_wr;
   logic [CODE_W-1:0]  edge_code;
   logic [NCNT_W-1:0]  node_num;
   logic [CAP_W-1:0]   cap_eff;
   logic               out_free;
   logic               eng_idle, res_valid;
   cecs_result_type    res;
   cecs_read_type      rd;
   logic [CODE_W-1:0]  edge_rd_data;
   logic [DEMAND_W-1:0] dem_rd_data;

   function automatic logic [CODE_W-1:0] quantize(input logic [VALUE_W-1:0] v,
                                                  input logic [TOL_W-1:0] tol);
      logic [VALUE_W-1:0] tol_ext;
      tol_ext = VALUE_W'(tol);
      if (v > ONE_FIX + tol_ext) begin
         return CODE_W'(2);
      end else if (v > tol_ext) begin
         return CODE_W'(1);
      end
      return CODE_W'(0);
   endfunction

   assign req_ready = eng_idle;
   assign csr_ready = 1'b1;
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      edge_wr   = req_xfer && (req_operation == OP_EDGE) && (req_node_a < req_node_b)
                  && (int'(req_node_b) < MAX_NODES);
      dem_wr    = req_xfer && (req_operation == OP_DEMAND)
                  && (int'(req_node_a) < MAX_NODES);
      edge_code = quantize(req_edge_value, tolerance_ff);
      node_num  = (int'(node_count_ff) > MAX_NODES) ? NCNT_W'(MAX_NODES)
                                                     : NCNT_W'(node_count_ff);
      cap_eff   = (capacity_ff == '0) ? CAP_W'(1) : capacity_ff;

      node_count_in = node_count_ff;
      capacity_in   = capacity_ff;
      tolerance_in  = tolerance_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_NODE_COUNT: node_count_in = csr_data[NCFG_W-1:0];
            REG_CAPACITY:   capacity_in   = csr_data[CAP_W-1:0];
            REG_TOLERANCE:  tolerance_in  = csr_data[TOL_W-1:0];
            default: begin
            end
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NCFG_W'(16);
         capacity_ff   <= CAP_W'(100);
         tolerance_ff  <= TOL_W'(7);
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         capacity_ff   <= capacity_in;
         tolerance_ff  <= tolerance_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   cecs_ram #(
      .WIDTH (CODE_W),
      .DEPTH (EDGE_DEPTH)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr),
      .wr_addr ({NODE_W'(req_node_a), NODE_W'(req_node_b)}),
      .wr_data (edge_code),
      .rd_en   (rd.en),
      .rd_addr (rd.edge_addr),
      .rd_data (edge_rd_data)
   );

   cecs_ram #(
      .WIDTH (DEMAND_W),
      .DEPTH (MAX_NODES)
   ) u_demand_ram (
      .clock   (clock),
      .wr_en   (dem_wr),
      .wr_addr (NODE_W'(req_node_a)),
      .wr_data (req_node_demand),
      .rd_en   (rd.en),
      .rd_addr (rd.dem_addr),
      .rd_data (dem_rd_data)
   );

   cecs_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (req_xfer && (req_operation == OP_SEARCH)),
      .node_num     (node_num),
      .capacity     (cap_eff),
      .out_free     (out_free),
      .edge_rd_data (edge_rd_data),
      .dem_rd_data  (dem_rd_data),
      .rd           (rd),
      .idle         (eng_idle),
      .res_valid    (res_valid),
      .res          (res)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_subset_mask = rsp_ff.mask;
   assign rsp_cut_bound   = rsp_ff.bound;
   assign rsp_cut_weight  = rsp_ff.weight;

endmodule
